[rtl/phase_vocoder_phase_propagation_top_assert.svh]
// Assertion macros shared by the phase propagation RTL.
`ifndef PHASE_VOCODER_PHASE_PROPAGATION_TOP_ASSERT_SVH
`define PHASE_VOCODER_PHASE_PROPAGATION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PVPP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvpp assertion failed");

// Next-cycle implication, checked outside reset.
`define PVPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvpp assertion failed");

`endif

[rtl/pvpp_pkg.sv]
// Shared types, constants and functions of the phase propagation block.
package pvpp_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int DATA_W       = 36;
   localparam int ANGLE_W      = 34;
   localparam int SAMPLE_W     = 24;
   localparam int MAG_W        = 26;
   localparam int MIN_MAG_W    = 23;
   localparam int GAIN_W       = 30;
   localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;

   localparam logic CSR_ENABLE        = 1'b0;
   localparam logic CSR_MIN_MAGNITUDE = 1'b1;

   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_EDGE = 2'd1,
      MODE_PROP = 2'd2
   } mode_type;

   function automatic logic [31:0] atan_turn(input int step);
      logic [31:0] r;
      begin
         unique case (step)
            0: r = 32'h20000000;
            1: r = 32'h12E4051E;
            2: r = 32'h09FB385B;
            3: r = 32'h051111D4;
            4: r = 32'h028B0D43;
            5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;
            7: r = 32'h00517C55;
            8: r = 32'h0028BE53;
            9: r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

   // Rounds a CORDIC output back to Q3.20 and clamps it to 24 bits.
   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [DATA_W-1:0] x);
      logic signed [DATA_W:0] sum;
      logic signed [DATA_W:0] sh;
      begin
         sum = {x[DATA_W-1], x} + (DATA_W+1)'(128);
         sh  = sum >>> 8;
         if (sh > (DATA_W+1)'(8388607)) begin
            return 24'sh7FFFFF;
         end else if (sh < -(DATA_W+1)'(8388608)) begin
            return 24'sh800000;
         end
         return sh[SAMPLE_W-1:0];
      end
   endfunction

endpackage

[rtl/pvpp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pvpp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 513
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pvpp_cordic_cell.sv]
// One CORDIC micro-rotation cell with its side payload, vectoring or rotating.
module pvpp_cordic_cell #(
   parameter int STEP   = 0,
   parameter bit VECTOR = 1'b1,
   parameter int TAG_W  = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic signed [pvpp_pkg::DATA_W-1:0]    in_x,
   input  logic signed [pvpp_pkg::DATA_W-1:0]    in_y,
   input  logic signed [pvpp_pkg::ANGLE_W-1:0]   in_z,
   input  logic [TAG_W-1:0]                      in_tag,
   output logic                                  out_valid,
   output logic signed [pvpp_pkg::DATA_W-1:0]    out_x,
   output logic signed [pvpp_pkg::DATA_W-1:0]    out_y,
   output logic signed [pvpp_pkg::ANGLE_W-1:0]   out_z,
   output logic [TAG_W-1:0]                      out_tag
);

   localparam logic signed [pvpp_pkg::ANGLE_W-1:0] ATAN =
      pvpp_pkg::ANGLE_W'(pvpp_pkg::atan_turn(STEP));

   logic signed [pvpp_pkg::DATA_W-1:0]  dx, dy, x_in, y_in, x_ff, y_ff;
   logic signed [pvpp_pkg::ANGLE_W-1:0] z_in, z_ff;
   logic [TAG_W-1:0]                    tag_ff;
   logic                                valid_ff;
   logic                                turn_neg;

   // Vectoring drives y toward zero, rotation drives the residual angle to zero.
   always_comb begin
      dx       = in_y >>> STEP;
      dy       = in_x >>> STEP;
      turn_neg = VECTOR ? in_y[pvpp_pkg::DATA_W-1] : !in_z[pvpp_pkg::ANGLE_W-1];
      if (turn_neg) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_tag   = tag_ff;

endmodule

[rtl/phase_vocoder_phase_propagation_top.sv]
// Top level of the phase vocoder phase propagation block.
//
// Bins enter on the req_ channel (bin index, signed Q3.20 real and imaginary)
// and leave on the rsp_ channel as signed Q3.20 saturated values, one result
// per transaction, in order. Both channels use valid/ready.
// The datapath is a fixed pipeline: 24 vectoring CORDIC cells, a gain and
// state update section, and 24 rotating CORDIC cells. One bin is accepted
// every cycle while the pipeline is not frozen and the clear pass is done.
// Per-bin phases live in one RAM with a one-transaction bypass, so the same
// bin may arrive in consecutive cycles.
// After reset the block clears all NUM_BINS entries (513 by default) of the
// phase RAM; req_ready is low during that pass, csr_ writes are taken as usual.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops until the result is taken.
// csr_we writes enable (index 0) or min_magnitude (index 1);
// write them only while no transaction is in flight.
module phase_vocoder_phase_propagation_top #(
   parameter int FFT_SIZE    = 1024,
   parameter int PHASE_WIDTH = 24,
   localparam int NUM_BINS   = FFT_SIZE / 2 + 1,
   localparam int BIN_W      = $clog2(NUM_BINS)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [BIN_W-1:0]                      req_bin_index,
   input  logic signed [pvpp_pkg::SAMPLE_W-1:0]  req_in_re,
   input  logic signed [pvpp_pkg::SAMPLE_W-1:0]  req_in_im,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pvpp_pkg::SAMPLE_W-1:0]  rsp_out_re,
   output logic signed [pvpp_pkg::SAMPLE_W-1:0]  rsp_out_im,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [pvpp_pkg::MIN_MAG_W-1:0]        csr_wdata
);

`include "phase_vocoder_phase_propagation_top_assert.svh"

   localparam int DW    = pvpp_pkg::DATA_W;
   localparam int AW    = pvpp_pkg::ANGLE_W;
   localparam int SW    = pvpp_pkg::SAMPLE_W;
   localparam int MW    = pvpp_pkg::MAG_W;
   localparam int GW    = pvpp_pkg::GAIN_W;
   localparam int STEPS = pvpp_pkg::CORDIC_STEPS;
   localparam int PW    = PHASE_WIDTH;
   localparam int SHIFT = 32 - PHASE_WIDTH;
   localparam logic [32:0] PH_ROUND = (SHIFT == 0) ? 33'd0 : 33'(64'd1 << (SHIFT - 1));
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

   typedef struct packed {
      pvpp_pkg::mode_type    mode;
      logic [BIN_W-1:0]      bin;
      logic signed [SW-1:0]  re;
      logic signed [SW-1:0]  im;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // Control and configuration.
   state_type                  state_ff, state_in;
   logic [BIN_W-1:0]           clr_cnt_ff, clr_cnt_in;
   logic                       enable_ff;
   logic [pvpp_pkg::MIN_MAG_W-1:0] min_mag_ff;
   logic                       advance;
   logic                       accept;

   // Pipeline registers outside the cell chains.
   logic                       s0_valid_ff;
   tag_type                    s0_tag_ff, s0_tag_in;
   logic                       m1_valid_ff, m2_valid_ff, m3_valid_ff, r0_valid_ff;
   tag_type                    m1_tag_ff, m2_tag_ff, m3_tag_ff, r0_tag_ff;
   logic [DW+GW-2:0]           m1_prod_ff;
   logic [PW-1:0]              m1_phase_ff, m2_phase_ff, m3_phase_ff;
   logic [MW-1:0]              m2_mag_ff, m3_mag_ff;
   logic [MW+GW-1:0]           r0_prod_ff;
   logic [PW-1:0]              r0_run_ff;
   logic                       r0_below_ff;
   logic                       out_valid_ff;
   logic signed [SW-1:0]       out_re_ff, out_im_ff, out_re_in, out_im_in;

   // Cell chain wiring.
   logic                       vv [STEPS+1];
   logic signed [DW-1:0]       vx [STEPS+1];
   logic signed [DW-1:0]       vy [STEPS+1];
   logic signed [AW-1:0]       vz [STEPS+1];
   logic [TAG_W-1:0]           vt [STEPS+1];
   logic                       rv [STEPS+1];
   logic signed [DW-1:0]       rx [STEPS+1];
   logic signed [DW-1:0]       ry [STEPS+1];
   logic signed [AW-1:0]       rz [STEPS+1];
   logic [TAG_W-1:0]           rt [STEPS+1];
   logic                       rbelow [STEPS+1];

   // Stage combinational values.
   logic [DW-2:0]              m1_x_clamp;
   logic [32:0]                m1_angle_sum;
   logic [DW+GW-1:0]           m2_mag_sum;
   logic                       m3_below;
   logic [2*PW-1:0]            m3_state;
   logic [PW-1:0]              m3_prev, m3_run, m3_new_run;
   logic [MW+GW-1:0]           m3_prod;
   logic                       upd_we;
   logic                       fwd_in;
   logic                       fwd_ff;
   logic [2*PW-1:0]            fwd_data_ff;
   logic [2*PW-1:0]            ram_rd_data;
   logic                       ram_we;
   logic [BIN_W-1:0]           ram_waddr;
   logic [2*PW-1:0]            ram_wdata;
   logic [MW+GW:0]             r0_x_sum;
   logic [31:0]                r0_z32;
   logic                       r0_flip;
   tag_type                    vout_tag, rout_tag;

   // ------------------------------------------------------------------
   // Flow control and configuration.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance && (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + BIN_W'(1);
            if (clr_cnt_ff == LAST_BIN) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         enable_ff  <= 1'b1;
         min_mag_ff <= pvpp_pkg::MIN_MAG_W'(1);
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         if (csr_we) begin
            unique case (csr_index)
               pvpp_pkg::CSR_ENABLE:        enable_ff  <= csr_wdata[0];
               pvpp_pkg::CSR_MIN_MAGNITUDE: min_mag_ff <= csr_wdata;
               default:                     enable_ff  <= enable_ff;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Input register and classification.
   always_comb begin
      s0_tag_in.bin = req_bin_index;
      s0_tag_in.re  = req_in_re;
      s0_tag_in.im  = req_in_im;
      priority if (!enable_ff || (req_bin_index > LAST_BIN)) begin
         s0_tag_in.mode = pvpp_pkg::MODE_PASS;
      end else if ((req_bin_index == '0) || (req_bin_index == LAST_BIN)) begin
         s0_tag_in.mode = pvpp_pkg::MODE_EDGE;
      end else begin
         s0_tag_in.mode = pvpp_pkg::MODE_PROP;
      end
   end

   // Valid bits of the registered stages outside the cell chains, and the bypass flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         r0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= accept;
         m1_valid_ff  <= vv[STEPS];
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         r0_valid_ff  <= m3_valid_ff;
         out_valid_ff <= rv[STEPS];
         fwd_ff       <= fwd_in;
      end
   end

   // Vectoring start: fold the left half plane onto the right.
   always_comb begin
      vv[0] = s0_valid_ff;
      vt[0] = s0_tag_ff;
      vx[0] = DW'(s0_tag_ff.re) <<< 8;
      vy[0] = DW'(s0_tag_ff.im) <<< 8;
      vz[0] = '0;
      if (s0_tag_ff.re < 0) begin
         vx[0] = -(DW'(s0_tag_ff.re) <<< 8);
         vy[0] = -(DW'(s0_tag_ff.im) <<< 8);
         vz[0] = AW'(33'h080000000);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      pvpp_cordic_cell #(
         .STEP   (i),
         .VECTOR (1'b1),
         .TAG_W  (TAG_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vv[i]),
         .in_x      (vx[i]),
         .in_y      (vy[i]),
         .in_z      (vz[i]),
         .in_tag    (vt[i]),
         .out_valid (vv[i+1]),
         .out_x     (vx[i+1]),
         .out_y     (vy[i+1]),
         .out_z     (vz[i+1]),
         .out_tag   (vt[i+1])
      );
   end

   // ------------------------------------------------------------------
   // Gain correction, phase quantization and per-bin state update.
   assign vout_tag     = tag_type'(vt[STEPS]);
   assign m1_x_clamp   = vx[STEPS][DW-1] ? '0 : vx[STEPS][DW-2:0];
   assign m1_angle_sum = {1'b0, vz[STEPS][31:0]} + PH_ROUND;
   assign m2_mag_sum   = {1'b0, m1_prod_ff} + (DW+GW)'(64'd1 << 37);
   assign m3_below     = m3_mag_ff < MW'(min_mag_ff);
   assign m3_state     = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign m3_prev      = m3_state[2*PW-1:PW];
   assign m3_run       = m3_state[PW-1:0];
   assign m3_new_run   = m3_run + m3_phase_ff - m3_prev;
   assign m3_prod      = m3_mag_ff * pvpp_pkg::INV_GAIN;
   assign upd_we       = advance && m3_valid_ff && !m3_below &&
                         (m3_tag_ff.mode == pvpp_pkg::MODE_PROP);
   // The RAM returns old data when the bin just read is written in the same cycle.
   assign fwd_in       = upd_we && m2_valid_ff && (m2_tag_ff.bin == m3_tag_ff.bin);

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_tag_ff   <= s0_tag_in;
         m1_tag_ff   <= vout_tag;
         m1_prod_ff  <= m1_x_clamp * pvpp_pkg::INV_GAIN;
         m1_phase_ff <= m1_angle_sum[31:SHIFT];
         m2_tag_ff   <= m1_tag_ff;
         m2_phase_ff <= m1_phase_ff;
         m2_mag_ff   <= m2_mag_sum[MW+37:38];
         m3_tag_ff   <= m2_tag_ff;
         m3_phase_ff <= m2_phase_ff;
         m3_mag_ff   <= m2_mag_ff;
         fwd_data_ff <= {m3_phase_ff, m3_new_run};
         r0_tag_ff   <= m3_tag_ff;
         r0_prod_ff  <= m3_prod;
         r0_run_ff   <= m3_new_run;
         r0_below_ff <= m3_below;
         out_re_ff   <= out_re_in;
         out_im_ff   <= out_im_in;
      end
   end

   assign ram_we    = (state_ff == ST_CLEAR) || upd_we;
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : m3_tag_ff.bin;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : {m3_phase_ff, m3_new_run};

   pvpp_ram #(
      .WIDTH (2 * PW),
      .DEPTH (NUM_BINS)
   ) u_phase_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (advance),
      .rd_addr (m2_tag_ff.bin),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Rotation start: scaled magnitude at the running phase.
   always_comb begin
      r0_x_sum = {1'b0, r0_prod_ff} + (MW+GW+1)'(64'd1 << 21);
      r0_z32   = 32'(r0_run_ff) << SHIFT;
      r0_flip  = r0_z32[31] ^ r0_z32[30];
      rv[0]    = r0_valid_ff;
      rt[0]    = r0_tag_ff;
      ry[0]    = '0;
      rx[0]    = DW'(r0_x_sum[MW+GW:22]);
      if (r0_flip) begin
         rx[0]  = -DW'(r0_x_sum[MW+GW:22]);
         r0_z32 = r0_z32 ^ 32'h80000000;
      end
      rz[0]    = AW'(signed'(r0_z32));
   end

   assign rbelow[0] = r0_below_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      pvpp_cordic_cell #(
         .STEP   (i),
         .VECTOR (1'b0),
         .TAG_W  (TAG_W + 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (rv[i]),
         .in_x      (rx[i]),
         .in_y      (ry[i]),
         .in_z      (rz[i]),
         .in_tag    ({rbelow[i], rt[i]}),
         .out_valid (rv[i+1]),
         .out_x     (rx[i+1]),
         .out_y     (ry[i+1]),
         .out_z     (rz[i+1]),
         .out_tag   ({rbelow[i+1], rt[i+1]})
      );
   end

   // ------------------------------------------------------------------
   // Output selection and register.
   assign rout_tag = tag_type'(rt[STEPS]);

   always_comb begin
      out_re_in = rout_tag.re;
      out_im_in = rout_tag.im;
      unique case (rout_tag.mode)
         pvpp_pkg::MODE_PASS: begin
            out_re_in = rout_tag.re;
            out_im_in = rout_tag.im;
         end
         pvpp_pkg::MODE_EDGE: begin
            out_re_in = rout_tag.re;
            out_im_in = '0;
         end
         pvpp_pkg::MODE_PROP: begin
            if (rbelow[STEPS]) begin
               out_re_in = '0;
               out_im_in = '0;
            end else begin
               out_re_in = pvpp_pkg::round_sat(rx[STEPS]);
               out_im_in = pvpp_pkg::round_sat(ry[STEPS]);
            end
         end
         default: begin
            out_re_in = rout_tag.re;
            out_im_in = rout_tag.im;
         end
      endcase
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_out_re = out_re_ff;
   assign rsp_out_im = out_im_ff;

   // ------------------------------------------------------------------
   `PVPP_ASSERT_IMPL(a_clear_pipe_empty, clock, reset, state_ff == ST_CLEAR, !m3_valid_ff)
   `PVPP_ASSERT_IMPL(a_fwd_after_write, clock, reset, $rose(fwd_ff), $past(upd_we))
   `PVPP_ASSERT_NEXT(a_clear_ends, clock, reset,
      (state_ff == ST_CLEAR) && (clr_cnt_ff == LAST_BIN), state_ff == ST_RUN)

endmodule
